/* rtl/rvalu_pkg.sv */
// Shared types and constants for the RV64I integer ALU with register file.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rvalu_pkg;

   localparam int REG_IDX_W   = 5;
   localparam int DATA_W      = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // request kinds carried in req_type
   typedef enum logic [2:0] {
      REQ_REG_OP    = 3'd0,
      REQ_IMM_OP    = 3'd1,
      REQ_LUI       = 3'd2,
      REQ_AUIPC     = 3'd3,
      REQ_REG_READ  = 3'd4,
      REQ_REG_WRITE = 3'd5
   } req_kind_type;

   // funct3 operation selectors
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // immediate bit that selects srai over srli
   localparam int SRAI_BIT = 10;

   typedef enum logic [3:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_SLL,
      ALU_SLT,
      ALU_SLTU,
      ALU_XOR,
      ALU_SRL,
      ALU_SRA,
      ALU_OR,
      ALU_AND
   } alu_op_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_FWD
   } src_sel_type;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src1_reg;
      logic [REG_IDX_W-1:0] src2_reg;
      logic [2:0]           funct3_code;
      logic [6:0]           funct7_code;
      logic [19:0]          imm_field;
      logic [DATA_W-1:0]    inst_pc;
      logic [DATA_W-1:0]    write_value;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]    result_value;
      logic                 writes_reg;
      logic [REG_IDX_W-1:0] written_index;
   } rsp_payload_type;

   // classified request handed from front to back
   typedef struct packed {
      alu_op_type           alu_op;
      logic                 a_from_reg;
      logic                 b_from_imm;
      logic [REG_IDX_W-1:0] src1_reg;
      logic [REG_IDX_W-1:0] src2_reg;
      logic [REG_IDX_W-1:0] report_index;
      logic                 wr_en;
      logic [DATA_W-1:0]    imm_value;
   } uop_type;

endpackage

`default_nettype wire

/* rtl/rvalu_front.sv */
// Front end: accepts requests and classifies them into ALU micro-ops.
// Depends on rvalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvalu_front #(
   parameter int NUM_REGS = 32
) (
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire rvalu_pkg::req_payload_type req_payload,
   input  wire logic                       q_full,
   output logic                            push,
   output rvalu_pkg::uop_type              uop
);

   function automatic rvalu_pkg::alu_op_type alu_decode(input logic [2:0] f3, input logic alt);
      rvalu_pkg::alu_op_type op;
      case (f3)
         rvalu_pkg::F3_ADD:  op = alt ? rvalu_pkg::ALU_SUB : rvalu_pkg::ALU_ADD;
         rvalu_pkg::F3_SLL:  op = rvalu_pkg::ALU_SLL;
         rvalu_pkg::F3_SLT:  op = rvalu_pkg::ALU_SLT;
         rvalu_pkg::F3_SLTU: op = rvalu_pkg::ALU_SLTU;
         rvalu_pkg::F3_XOR:  op = rvalu_pkg::ALU_XOR;
         rvalu_pkg::F3_SR:   op = alt ? rvalu_pkg::ALU_SRA : rvalu_pkg::ALU_SRL;
         rvalu_pkg::F3_OR:   op = rvalu_pkg::ALU_OR;
         rvalu_pkg::F3_AND:  op = rvalu_pkg::ALU_AND;
         default:            op = rvalu_pkg::ALU_ADD;
      endcase
      return op;
   endfunction

   logic                        rd_ok;
   logic [rvalu_pkg::DATA_W-1:0] imm12;
   logic [rvalu_pkg::DATA_W-1:0] upper;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   assign rd_ok = (req_payload.dest_reg != '0) && (int'(req_payload.dest_reg) < NUM_REGS);
   assign imm12 = {{52{req_payload.imm_field[11]}}, req_payload.imm_field[11:0]};
   assign upper = {{32{req_payload.imm_field[19]}}, req_payload.imm_field, 12'd0};

   always_comb begin
      uop              = '0;
      uop.alu_op       = rvalu_pkg::ALU_ADD;
      uop.a_from_reg   = 1'b0;
      uop.b_from_imm   = 1'b1;
      uop.src1_reg     = req_payload.src1_reg;
      uop.src2_reg     = req_payload.src2_reg;
      uop.report_index = '0;
      uop.wr_en        = 1'b0;
      uop.imm_value    = '0;
      case (req_payload.req_type)
         rvalu_pkg::REQ_REG_OP: begin
            uop.alu_op       = alu_decode(req_payload.funct3_code,
                                          req_payload.funct7_code != '0);
            uop.a_from_reg   = 1'b1;
            uop.b_from_imm   = 1'b0;
            uop.report_index = req_payload.dest_reg;
            uop.wr_en        = rd_ok;
         end
         rvalu_pkg::REQ_IMM_OP: begin
            uop.alu_op       = alu_decode(req_payload.funct3_code,
                                          (req_payload.funct3_code == rvalu_pkg::F3_SR) &&
                                          req_payload.imm_field[rvalu_pkg::SRAI_BIT]);
            uop.a_from_reg   = 1'b1;
            uop.imm_value    = imm12;
            uop.report_index = req_payload.dest_reg;
            uop.wr_en        = rd_ok;
         end
         rvalu_pkg::REQ_LUI: begin
            uop.imm_value    = upper;
            uop.report_index = req_payload.dest_reg;
            uop.wr_en        = rd_ok;
         end
         rvalu_pkg::REQ_AUIPC: begin
            uop.imm_value    = req_payload.inst_pc + upper;
            uop.report_index = req_payload.dest_reg;
            uop.wr_en        = rd_ok;
         end
         rvalu_pkg::REQ_REG_READ: begin
            uop.a_from_reg   = 1'b1;
            uop.report_index = req_payload.src1_reg;
         end
         rvalu_pkg::REQ_REG_WRITE: begin
            uop.imm_value    = req_payload.write_value;
            uop.report_index = req_payload.dest_reg;
            uop.wr_en        = rd_ok;
         end
         default: begin
            uop.imm_value = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/rvalu_queue.sv */
// Short request queue between the front end and the execute back end.
// Depends on rvalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvalu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rvalu_pkg::uop_type push_uop,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output rvalu_pkg::uop_type      head_uop
);

   rvalu_pkg::uop_type            entries_ff [rvalu_pkg::QUEUE_DEPTH];
   logic [rvalu_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rvalu_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rvalu_pkg::QPTR_W:0]    count_ff, count_in;

   assign full     = (count_ff == (rvalu_pkg::QPTR_W + 1)'(rvalu_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_uop = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_uop;
      end
   end

endmodule

`default_nettype wire

/* rtl/rvalu_back.sv */
// Back end: register file read with write forwarding, ALU, writeback and
// the registered response stage. Depends on rvalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvalu_back #(
   parameter int NUM_REGS = 32,
   parameter int XLEN     = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rvalu_pkg::uop_type head_uop,
   input  wire logic               q_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rvalu_pkg::rsp_payload_type rsp_payload
);

   localparam int AW  = $clog2(NUM_REGS);
   localparam int SHW = $clog2(XLEN);

   function automatic rvalu_pkg::src_sel_type src_select(
      input logic [rvalu_pkg::REG_IDX_W-1:0] idx,
      input logic                            fwd_hit,
      input logic                            valid_bit
   );
      rvalu_pkg::src_sel_type sel;
      if ((idx == '0) || (int'(idx) >= NUM_REGS)) begin
         sel = rvalu_pkg::SRC_ZERO;
      end else if (fwd_hit) begin
         sel = rvalu_pkg::SRC_FWD;
      end else if (valid_bit) begin
         sel = rvalu_pkg::SRC_MEM;
      end else begin
         sel = rvalu_pkg::SRC_ZERO;
      end
      return sel;
   endfunction

   logic [XLEN-1:0]              regs [NUM_REGS];
   logic [NUM_REGS-1:0]          valid_ff, valid_in;

   logic                         r_valid_ff, r_valid_in;
   rvalu_pkg::uop_type           r_uop_ff, r_uop_in;
   rvalu_pkg::src_sel_type       rs1_sel_ff, rs1_sel_in;
   rvalu_pkg::src_sel_type       rs2_sel_ff, rs2_sel_in;
   logic [XLEN-1:0]              rs1_mem_ff, rs2_mem_ff;
   logic [XLEN-1:0]              fwd_ff, fwd_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   rvalu_pkg::rsp_payload_type   rsp_ff, rsp_in;

   logic                         r_adv;
   logic                         wr_fire;
   logic [AW-1:0]                wr_addr;
   logic [XLEN-1:0]              src1, src2, op_a, op_b, alu_result;
   logic [SHW-1:0]               shamt;

   assign r_adv   = r_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop     = !q_empty && (!r_valid_ff || r_adv);
   assign wr_fire = r_adv && r_uop_ff.wr_en;
   assign wr_addr = r_uop_ff.report_index[AW-1:0];

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // operand selection
   always_comb begin
      case (rs1_sel_ff)
         rvalu_pkg::SRC_MEM: src1 = rs1_mem_ff;
         rvalu_pkg::SRC_FWD: src1 = fwd_ff;
         default:            src1 = '0;
      endcase
      case (rs2_sel_ff)
         rvalu_pkg::SRC_MEM: src2 = rs2_mem_ff;
         rvalu_pkg::SRC_FWD: src2 = fwd_ff;
         default:            src2 = '0;
      endcase
      op_a  = r_uop_ff.a_from_reg ? src1 : '0;
      op_b  = r_uop_ff.b_from_imm ? r_uop_ff.imm_value[XLEN-1:0] : src2;
      shamt = op_b[SHW-1:0] & SHW'(XLEN - 1);
   end

   always_comb begin
      case (r_uop_ff.alu_op)
         rvalu_pkg::ALU_ADD:  alu_result = op_a + op_b;
         rvalu_pkg::ALU_SUB:  alu_result = op_a - op_b;
         rvalu_pkg::ALU_SLL:  alu_result = op_a << shamt;
         rvalu_pkg::ALU_SLT:  alu_result = XLEN'($signed(op_a) < $signed(op_b));
         rvalu_pkg::ALU_SLTU: alu_result = XLEN'(op_a < op_b);
         rvalu_pkg::ALU_XOR:  alu_result = op_a ^ op_b;
         rvalu_pkg::ALU_SRL:  alu_result = op_a >> shamt;
         rvalu_pkg::ALU_SRA:  alu_result = XLEN'($signed(op_a) >>> shamt);
         rvalu_pkg::ALU_OR:   alu_result = op_a | op_b;
         rvalu_pkg::ALU_AND:  alu_result = op_a & op_b;
         default:             alu_result = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_fire) begin
         valid_in[wr_addr] = 1'b1;
      end

      r_valid_in = r_valid_ff;
      r_uop_in   = r_uop_ff;
      rs1_sel_in = rs1_sel_ff;
      rs2_sel_in = rs2_sel_ff;
      fwd_in     = fwd_ff;
      if (pop) begin
         r_valid_in = 1'b1;
         r_uop_in   = head_uop;
         rs1_sel_in = src_select(head_uop.src1_reg,
                                 wr_fire && (head_uop.src1_reg == r_uop_ff.report_index),
                                 valid_ff[head_uop.src1_reg[AW-1:0]]);
         rs2_sel_in = src_select(head_uop.src2_reg,
                                 wr_fire && (head_uop.src2_reg == r_uop_ff.report_index),
                                 valid_ff[head_uop.src2_reg[AW-1:0]]);
         fwd_in     = alu_result;
      end else if (r_adv) begin
         r_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (r_adv) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_value  = rvalu_pkg::DATA_W'(alu_result);
         rsp_in.writes_reg    = r_uop_ff.wr_en;
         rsp_in.written_index = r_uop_ff.report_index;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         r_valid_ff   <= r_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_uop_ff   <= r_uop_in;
      rs1_sel_ff <= rs1_sel_in;
      rs2_sel_ff <= rs2_sel_in;
      fwd_ff     <= fwd_in;
      rsp_ff     <= rsp_in;
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         regs[wr_addr] <= alu_result;
      end
      if (pop) begin
         rs1_mem_ff <= regs[head_uop.src1_reg[AW-1:0]];
         rs2_mem_ff <= regs[head_uop.src2_reg[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

/* rtl/rv64i_integer_alu_regfile.sv */
// RV64I integer ALU with register file: top level.
// Uses rvalu_pkg, rvalu_front, rvalu_queue and rvalu_back.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes one decoded request:
//   reg-reg op, reg-imm op, lui, auipc, register read or register write.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns exactly one
//   response per request, in order.
//   A request passes through the queue, the register-file read stage, and
//   the ALU and writeback into the response register. Throughput: one
//   request per cycle while rsp_ready stays high, limited by the single
//   register-file write port; a dependent request right behind a write is
//   served by forwarding the ALU result.
//   The two-entry queue lets the front keep accepting while the back end
//   is held; when rsp_ready stays low the response register holds, the back
//   end stops and req_ready drops once the queue fills.
//   Reset clears the queue, the pipeline and all register valid bits, so
//   every register reads zero; x0 always reads zero and is never written.
`timescale 1ns / 1ps
`default_nettype none

module rv64i_integer_alu_regfile #(
   parameter int NUM_REGS = 32,
   parameter int XLEN     = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire rvalu_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rvalu_pkg::rsp_payload_type      rsp_payload
);

   rvalu_pkg::uop_type dec_uop;
   rvalu_pkg::uop_type head_uop;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;

   rvalu_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .uop         (dec_uop)
   );

   rvalu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_uop (dec_uop),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_uop (head_uop)
   );

   rvalu_back #(
      .NUM_REGS (NUM_REGS),
      .XLEN     (XLEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_uop    (head_uop),
      .q_empty     (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* rtl/rvalu_checker.sv */
// Port-level assertions for rv64i_integer_alu_regfile, bound to the top level.
// Depends on rvalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvalu_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire rvalu_pkg::rsp_payload_type rsp_payload
);

   // pipeline and queue come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("response pending or queue not empty after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped or changed while stalled");

   // x0 is never reported as written
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.writes_reg) |-> (rsp_payload.written_index != '0))
      else $error("write to x0 reported");

   // no response appears too early out of reset: a request taken first must
   // pass the queue, the read stage and the response register before rsp_valid
   a_min_latency: assert property (@(posedge clock)
      $fell(reset) |-> (!rsp_valid ##1 !rsp_valid ##1 !rsp_valid))
      else $error("response appeared too early");

endmodule

bind rv64i_integer_alu_regfile rvalu_checker u_checker (.*);

`default_nettype wire
